>>> src/mws_pkg.sv
// Shared types and constants of the mecanum wheel speed solver.
`default_nettype none
package mws_pkg;

  localparam int NWHEEL     = 4;
  localparam int WHL_W      = 2;
  localparam int VEL_W      = 16;
  localparam int COMBO_W    = 29;
  localparam int SUM_W      = 30;
  localparam int RAD_W      = 18;
  localparam int LEN_W      = 12;
  localparam int GEAR_W     = 16;
  localparam int RPM_W      = 17;
  localparam int K_W        = 20;
  localparam int GK_W       = 36;
  localparam int GK_LO_W    = 18;
  localparam int PP_W       = 47;
  localparam int PROD_W     = 65;
  localparam int QUO_W      = 41;
  localparam int SCALE_W    = 17;
  localparam int SNUM_W     = 32;
  localparam int MASK_W     = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_W      = 85;
  localparam int OUT_DATA_W = 88;
  localparam int QUEUE_DEPTH = 2;

  // 30/pi in unsigned Q16, rounded to nearest
  localparam logic [K_W-1:0] K_Q16 = 20'd625823;
  localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;

  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_WB  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_TR  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GEAR     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RPM  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_REV_MASK = 3'd5;

  typedef struct packed {
    logic [RAD_W-1:0]  radius;
    logic [LEN_W-1:0]  half_wb;
    logic [LEN_W-1:0]  half_tr;
    logic [GEAR_W-1:0] gear;
    logic [GEAR_W-1:0] max_rpm;
    logic [MASK_W-1:0] rev_mask;
  } cfg_t;

  // one classified command: rim speed magnitudes in um/s and signs
  typedef struct packed {
    logic [NWHEEL-1:0][COMBO_W-1:0] mag;
    logic [NWHEEL-1:0]              neg;
    logic                           zero_arm;
  } cmd_t;

  typedef struct packed {
    logic [WHL_W-1:0] wheel;
    logic             neg;
    logic             zero_arm;
  } wside_t;

  typedef struct packed {
    logic                         zero_arm;
    logic                         need;
    logic [NWHEEL-1:0]            neg;
    logic [NWHEEL-1:0][QUO_W-1:0] mag;
  } rec_t;

endpackage
`default_nettype wire

>>> src/mecanum_wheel_speed_solver.sv
// Top level of the mecanum wheel speed solver: config registers, front end, queue, back end.
//
//  channel  | handshake                    | contents
//  ---------+------------------------------+-------------------------------------------
//  cmd in   | s_axis_tvalid/s_axis_tready  | vx, vy, wz velocity command
//  rpm out  | m_axis_tvalid/m_axis_tready  | four motor rpm, scale; tuser = bad arm
//  config   | cfg_we_i (no wait)           | register at cfg_addr_i <= cfg_wdata_i
//
// The rpm divider is shared by the four wheels, one wheel per cycle while the back end
// is not stalled; a command leaves the queue with its last wheel. An item passes the
// multiply stages, the 41-stage rpm divider, the gather stage, the 32-stage scale
// divider and the output register. A two-entry queue lets the input keep taking items
// while the output stalls; a stall on m_axis_tready freezes the whole back end. Reset
// loads the documented register defaults.
`default_nettype none
module mecanum_wheel_speed_solver (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] vx_mmps, [31:16] vy_mmps, [47:32] wz_mradps
  input  wire logic [mws_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [16:0] rpm_front_left, [33:17] rpm_front_right, [50:34] rpm_rear_left,
  // [67:51] rpm_rear_right, [84:68] scale_q16, [87:85] zero
  output logic [mws_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // [0] status
  output logic                                    m_axis_tuser,
  input  wire logic                               cfg_we_i,
  input  wire logic [mws_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [mws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import mws_pkg::*;

  cfg_t             cfg_q;
  logic             q_full, q_push, q_valid, q_pop;
  cmd_t             cmd, q_data;
  logic [OUT_W-1:0] out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius   <= RAD_W'(50000);
      cfg_q.half_wb  <= LEN_W'(200);
      cfg_q.half_tr  <= LEN_W'(200);
      cfg_q.gear     <= GEAR_W'(4864);
      cfg_q.max_rpm  <= GEAR_W'(9000);
      cfg_q.rev_mask <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_RADIUS:   cfg_q.radius   <= cfg_wdata_i[RAD_W-1:0];
        CFG_HALF_WB:  cfg_q.half_wb  <= cfg_wdata_i[LEN_W-1:0];
        CFG_HALF_TR:  cfg_q.half_tr  <= cfg_wdata_i[LEN_W-1:0];
        CFG_GEAR:     cfg_q.gear     <= cfg_wdata_i[GEAR_W-1:0];
        CFG_MAX_RPM:  cfg_q.max_rpm  <= cfg_wdata_i[GEAR_W-1:0];
        CFG_REV_MASK: cfg_q.rev_mask <= cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  mws_front u_front (
    .cfg_i      (cfg_q),
    .vx_i       ($signed(s_axis_tdata[15:0])),
    .vy_i       ($signed(s_axis_tdata[31:16])),
    .wz_i       ($signed(s_axis_tdata[47:32])),
    .in_valid_i (s_axis_tvalid),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .q_push_o   (q_push),
    .cmd_o      (cmd)
  );

  mws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  mws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (out_data),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {(OUT_DATA_W-OUT_W)'(0), out_data};

endmodule
`default_nettype wire

>>> src/mws_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module mws_div_pipe #(
  parameter int NUM_W  = 41,
  parameter int DEN_W  = 18,
  parameter int SIDE_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [NUM_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [NUM_W-1:0]  vld_q;
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [NUM_W-1:0]  quo_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              vld_p;
    logic [DEN_W-1:0]  rem_p;
    logic [NUM_W-1:0]  num_p;
    logic [NUM_W-1:0]  quo_p;
    logic [DEN_W-1:0]  den_p;
    logic [SIDE_W-1:0] side_p;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign vld_p  = valid_i;
      assign rem_p  = '0;
      assign num_p  = num_i;
      assign quo_p  = '0;
      assign den_p  = den_i;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign num_p  = num_q[s-1];
      assign quo_p  = quo_q[s-1];
      assign den_p  = den_q[s-1];
      assign side_p = side_q[s-1];
    end

    assign trial = {rem_p, num_p[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_q[s]  <= {num_p[NUM_W-2:0], 1'b0};
        quo_q[s]  <= {quo_p[NUM_W-2:0], ge};
        den_q[s]  <= den_p;
        side_q[s] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = quo_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule
`default_nettype wire

>>> src/mws_front.sv
// Front end: forms the four signed rim speed combinations of a command.
`default_nettype none
module mws_front (
  input  wire mws_pkg::cfg_t                     cfg_i,
  input  wire logic signed [mws_pkg::VEL_W-1:0]  vx_i,
  input  wire logic signed [mws_pkg::VEL_W-1:0]  vy_i,
  input  wire logic signed [mws_pkg::VEL_W-1:0]  wz_i,
  input  wire logic                              in_valid_i,
  input  wire logic                              q_full_i,
  output logic                                   in_ready_o,
  output logic                                   q_push_o,
  output mws_pkg::cmd_t                          cmd_o
);
  import mws_pkg::*;

  logic [LEN_W:0]           arm;
  logic signed [SUM_W-1:0]  vx_k;
  logic signed [SUM_W-1:0]  vy_k;
  logic signed [SUM_W-1:0]  awz;
  logic signed [SUM_W-1:0]  combo [NWHEEL];
  logic [SUM_W-1:0]         absval [NWHEEL];

  assign arm  = {1'b0, cfg_i.half_wb} + {1'b0, cfg_i.half_tr};
  assign vx_k = $signed(SUM_W'(vx_i)) * $signed(SUM_W'(1000));
  assign vy_k = $signed(SUM_W'(vy_i)) * $signed(SUM_W'(1000));
  assign awz  = $signed({{(SUM_W-LEN_W-1){1'b0}}, arm}) * $signed(SUM_W'(wz_i));

  // X layout: FL, FR, RL, RR
  assign combo[0] = vx_k - vy_k - awz;
  assign combo[1] = vx_k + vy_k + awz;
  assign combo[2] = vx_k + vy_k - awz;
  assign combo[3] = vx_k - vy_k + awz;

  always_comb begin
    for (int k = 0; k < NWHEEL; k++) begin
      absval[k]     = combo[k][SUM_W-1] ? SUM_W'(-combo[k]) : SUM_W'(combo[k]);
      cmd_o.mag[k]  = absval[k][COMBO_W-1:0];
      cmd_o.neg[k]  = combo[k][SUM_W-1] ^ cfg_i.rev_mask[k];
    end
    cmd_o.zero_arm = (arm == '0);
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule
`default_nettype wire

>>> src/mws_fifo.sv
// Short command queue between front end and back end.
`default_nettype none
module mws_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mws_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output mws_pkg::cmd_t      data_o
);
  import mws_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> src/mws_back.sv
// Back end: rpm conversion per wheel, peak search, common scaling, output register.
`default_nettype none
module mws_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mws_pkg::cfg_t                 cfg_i,
  input  wire logic                          q_valid_i,
  input  wire mws_pkg::cmd_t                 q_data_i,
  output logic                               q_pop_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [mws_pkg::OUT_W-1:0]          out_data_o,
  output logic                               out_status_o
);
  import mws_pkg::*;

  logic                 adv;
  logic [GK_W-1:0]      gk_q;
  logic [RAD_W-1:0]     rad;
  logic [WHL_W-1:0]     cnt_q;
  logic                 issue;
  logic [COMBO_W-1:0]   sel_mag;

  logic                 m1_vld_q;
  logic [PP_W-1:0]      p_lo_q, p_hi_q;
  wside_t               m1_side_q;
  logic [PROD_W-1:0]    prod;
  logic                 m2_vld_q;
  logic [QUO_W-1:0]     m2_num_q;
  wside_t               m2_side_q;

  logic                 w_vld;
  logic [QUO_W-1:0]     w_quo;
  wside_t               w_side;
  logic                 w_neg;
  logic [QUO_W-1:0]     max_new;
  logic [QUO_W-1:0]     acc_mag_q [NWHEEL];
  logic [NWHEEL-1:0]    acc_neg_q;
  logic [QUO_W-1:0]     acc_max_q;

  logic                 g_vld_q;
  rec_t                 g_rec_q;
  logic [QUO_W-1:0]     g_max_q;
  rec_t                 g_rec_d;

  logic                 s_vld;
  logic [SNUM_W-1:0]    s_quo;
  rec_t                 s_rec;

  logic [SCALE_W-1:0]   scale;
  logic [QUO_W+SCALE_W-1:0] sprod [NWHEEL];
  logic [RPM_W-1:0]     mres [NWHEEL];
  logic [RPM_W-1:0]     rpm [NWHEEL];
  logic                 nk [NWHEEL];
  logic [OUT_W-1:0]     out_d;

  logic                 out_vld_q;
  logic [OUT_W-1:0]     out_data_q;
  logic                 out_status_q;

  // whole back end moves while the output slot is free or being taken
  assign adv = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    gk_q <= GK_W'(cfg_i.gear) * GK_W'(K_Q16);
  end

  assign rad = (cfg_i.radius == '0) ? RAD_W'(1) : cfg_i.radius;

  // issue one wheel per cycle while the back end advances, pop the command with its last wheel
  assign issue   = q_valid_i && adv;
  assign q_pop_o = issue && (cnt_q == WHL_W'(NWHEEL - 1));
  assign sel_mag = q_data_i.mag[cnt_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      g_vld_q  <= 1'b0;
    end else if (adv) begin
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      m1_vld_q <= issue;
      m2_vld_q <= m1_vld_q;
      g_vld_q  <= w_vld && (w_side.wheel == WHL_W'(NWHEEL - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_lo_q <= PP_W'(sel_mag) * PP_W'(gk_q[GK_LO_W-1:0]);
      p_hi_q <= PP_W'(sel_mag) * PP_W'(gk_q[GK_W-1:GK_LO_W]);
      m1_side_q.wheel    <= cnt_q;
      m1_side_q.neg      <= q_data_i.neg[cnt_q];
      m1_side_q.zero_arm <= q_data_i.zero_arm;
      m2_num_q  <= prod[PROD_W-1:24];
      m2_side_q <= m1_side_q;
    end
  end

  assign prod = PROD_W'(p_lo_q) + (PROD_W'(p_hi_q) << GK_LO_W);

  mws_div_pipe #(
    .NUM_W  (QUO_W),
    .DEN_W  (RAD_W),
    .SIDE_W ($bits(wside_t))
  ) u_wheel_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m2_vld_q),
    .num_i   (m2_num_q),
    .den_i   (rad),
    .side_i  (m2_side_q),
    .valid_o (w_vld),
    .quo_o   (w_quo),
    .side_o  (w_side)
  );

  // gather the four wheels of one command and track the peak
  assign w_neg   = w_side.neg && (w_quo != '0);
  assign max_new = ((w_side.wheel == '0) || (w_quo > acc_max_q)) ? w_quo : acc_max_q;

  always_comb begin
    for (int k = 0; k < NWHEEL - 1; k++) begin
      g_rec_d.mag[k] = acc_mag_q[k];
      g_rec_d.neg[k] = acc_neg_q[k];
    end
    g_rec_d.mag[NWHEEL-1] = w_quo;
    g_rec_d.neg[NWHEEL-1] = w_neg;
    g_rec_d.zero_arm      = w_side.zero_arm;
    g_rec_d.need          = max_new > QUO_W'(cfg_i.max_rpm);
  end

  always_ff @(posedge clk_i) begin
    if (adv && w_vld) begin
      acc_mag_q[w_side.wheel] <= w_quo;
      acc_neg_q[w_side.wheel] <= w_neg;
      acc_max_q               <= max_new;
    end
    if (adv) begin
      g_rec_q <= g_rec_d;
      g_max_q <= max_new;
    end
  end

  mws_div_pipe #(
    .NUM_W  (SNUM_W),
    .DEN_W  (QUO_W),
    .SIDE_W ($bits(rec_t))
  ) u_scale_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g_vld_q),
    .num_i   ({cfg_i.max_rpm, 16'b0}),
    .den_i   (g_max_q),
    .side_i  (g_rec_q),
    .valid_o (s_vld),
    .quo_o   (s_quo),
    .side_o  (s_rec)
  );

  assign scale = s_rec.need ? s_quo[SCALE_W-1:0] : SCALE_ONE;

  always_comb begin
    for (int k = 0; k < NWHEEL; k++) begin
      sprod[k] = (QUO_W+SCALE_W)'(s_rec.mag[k]) * (QUO_W+SCALE_W)'(scale);
      mres[k]  = s_rec.need ? sprod[k][RPM_W+15:16] : s_rec.mag[k][RPM_W-1:0];
      nk[k]    = s_rec.neg[k] && (mres[k] != '0);
      rpm[k]   = nk[k] ? RPM_W'(-mres[k]) : mres[k];
    end
    out_d = {scale, rpm[3], rpm[2], rpm[1], rpm[0]};
    // zero rotation arm: blank the whole result
    if (s_rec.zero_arm) begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_vld) begin
      out_data_q   <= out_d;
      out_status_q <= s_rec.zero_arm;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

endmodule
`default_nettype wire

>>> src/mws_checker.sv
// Port-level checks of the mecanum wheel speed solver, bound to the top level.
`default_nettype none
module mws_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_bad_arm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 88'd0)
    else $error("bad rotation arm result not blanked");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[84:68] <= 17'h10000)
    else $error("scale above one");

  a_rpm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:0] != 17'h10000 && m_axis_tdata[33:17] != 17'h10000
      && m_axis_tdata[50:34] != 17'h10000 && m_axis_tdata[67:51] != 17'h10000)
    else $error("rpm out of range");

  a_unscaled_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[87:85] == 3'd0)
    else $error("tdata padding not zero");

endmodule

bind mecanum_wheel_speed_solver mws_checker u_mws_checker (.*);
`default_nettype wire

>>> verif/tb_mecanum_wheel_speed_solver.sv
// Self-checking testbench for the mecanum wheel speed solver stream block.
`timescale 1ns / 1ps
module tb_mecanum_wheel_speed_solver;
  import mws_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_RANDOM     = 1000;

  typedef struct {
    logic signed [RPM_W-1:0] rpm[NWHEEL];
    logic [SCALE_W-1:0]      scale;
    logic                    bad_arm;
  } wheel_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  mecanum_wheel_speed_solver dut (.*);

  // local copy of the configuration
  logic [RAD_W-1:0]  radius_um;
  logic [LEN_W-1:0]  half_wb_mm, half_tr_mm;
  logic [GEAR_W-1:0] gear_q8, rpm_limit;
  logic [MASK_W-1:0] rev_mask;

  wheel_cmd_t expected_cmds[$];
  int  n_errors = 0;
  int  n_checked = 0;
  int  n_sent = 0;
  longint cycle = 0;
  bit  hold_off = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on item %0d: %s got %0d expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  // rpm for every wheel from one velocity command
  function automatic wheel_cmd_t solve_wheels(input logic signed [15:0] vx,
                                              input logic signed [15:0] vy,
                                              input logic signed [15:0] wz);
    wheel_cmd_t r;
    longint arm, c, rad, maxabs, sc;
    longint mag[NWHEEL];
    bit neg[NWHEEL];
    logic [127:0] wide;
    arm = longint'(half_wb_mm) + longint'(half_tr_mm);
    rad = (radius_um == 0) ? 1 : longint'(radius_um);
    maxabs = 0;
    sc = 65536;
    r.bad_arm = (arm == 0);
    if (arm == 0) begin
      foreach (r.rpm[k]) r.rpm[k] = '0;
      r.scale = '0;
      return r;
    end
    for (int k = 0; k < NWHEEL; k++) begin
      // FL: -vy -wz, FR: +vy +wz, RL: +vy -wz, RR: -vy +wz
      c = 1000 * longint'(vx)
        + ((k == 1 || k == 2) ? 1000 * longint'(vy) : -1000 * longint'(vy))
        + ((k == 1 || k == 3) ? arm * longint'(wz) : -arm * longint'(wz));
      neg[k] = (c < 0);
      if (c < 0) c = -c;
      wide = 128'(c) * 128'(gear_q8) * 128'(K_Q16) / (128'(rad) << 24);
      mag[k] = longint'(wide);
      if (rev_mask[k]) neg[k] = !neg[k];
      if (mag[k] == 0) neg[k] = 1'b0;
      if (mag[k] > maxabs) maxabs = mag[k];
    end
    if (maxabs > longint'(rpm_limit)) begin
      sc = (longint'(rpm_limit) << 16) / maxabs;
      for (int k = 0; k < NWHEEL; k++) begin
        mag[k] = (mag[k] * sc) >>> 16;
        if (mag[k] == 0) neg[k] = 1'b0;
      end
    end
    for (int k = 0; k < NWHEEL; k++)
      r.rpm[k] = neg[k] ? -RPM_W'(mag[k]) : RPM_W'(mag[k]);
    r.scale = SCALE_W'(sc);
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RADIUS:   radius_um  = val[RAD_W-1:0];
      CFG_HALF_WB:  half_wb_mm = val[LEN_W-1:0];
      CFG_HALF_TR:  half_tr_mm = val[LEN_W-1:0];
      CFG_GEAR:     gear_q8    = val[GEAR_W-1:0];
      CFG_MAX_RPM:  rpm_limit  = val[GEAR_W-1:0];
      CFG_REV_MASK: rev_mask   = val[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int rad, input int wb, input int tr, input int gear,
                            input int lim, input int mask);
    write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
    write_reg(CFG_HALF_WB, CFG_DATA_W'(wb));
    write_reg(CFG_HALF_TR, CFG_DATA_W'(tr));
    write_reg(CFG_GEAR, CFG_DATA_W'(gear));
    write_reg(CFG_MAX_RPM, CFG_DATA_W'(lim));
    write_reg(CFG_REV_MASK, CFG_DATA_W'(mask));
  endtask

  // offer one command; called at a falling edge, returns at a falling edge after acceptance
  task automatic send_cmd(input logic [15:0] vx, input logic [15:0] vy, input logic [15:0] wz,
                          input bit with_gap, input bit has_want = 0,
                          input wheel_cmd_t want = '{default: '0});
    int gap;
    gap = with_gap ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {wz, vy, vx};
    expected_cmds.push_back(has_want ? want : solve_wheels(vx, vy, wz));
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // receiver: random stalls, long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      stall = (n_sent % 200 < 100) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // checker
  always @(posedge clk_i) begin
    wheel_cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_cmds.size() == 0) begin
        $display("unexpected result item");
        n_errors++;
      end else begin
        want = expected_cmds.pop_front();
        for (int k = 0; k < NWHEEL; k++)
          if (m_axis_tdata[k*RPM_W +: RPM_W] !== want.rpm[k])
            report_mismatch($sformatf("rpm[%0d]", k),
                            longint'($signed(m_axis_tdata[k*RPM_W +: RPM_W])),
                            longint'(want.rpm[k]));
        if (m_axis_tdata[NWHEEL*RPM_W +: SCALE_W] !== want.scale)
          report_mismatch("scale", m_axis_tdata[NWHEEL*RPM_W +: SCALE_W], want.scale);
        if (m_axis_tuser !== want.bad_arm)
          report_mismatch("status", m_axis_tuser, want.bad_arm);
        n_checked++;
      end
    end
  end

  typedef struct {
    logic [15:0] vx, vy, wz;
    bit          typed;
    wheel_cmd_t  want;
  } cmd_row_t;

  wheel_cmd_t zero_res = '{rpm: '{default: '0}, scale: SCALE_ONE, bad_arm: 1'b0};
  wheel_cmd_t bad_res  = '{rpm: '{default: '0}, scale: '0, bad_arm: 1'b1};
  cmd_row_t directed[];

  function automatic logic [15:0] rand_vel(input int mode);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  initial begin
    int mode;
    radius_um = 50000; half_wb_mm = 200; half_tr_mm = 200;
    gear_q8 = 4864; rpm_limit = 9000; rev_mask = 0;
    directed = '{
      '{16'h0000, 16'h0000, 16'h0000, 1, zero_res},
      '{16'h7fff, 16'h0000, 16'h0000, 0, zero_res},
      '{16'h8000, 16'h0000, 16'h0000, 0, zero_res},
      '{16'h0000, 16'h7fff, 16'h0000, 0, zero_res},
      '{16'h0000, 16'h8000, 16'h0000, 0, zero_res},
      '{16'h0000, 16'h0000, 16'h7fff, 0, zero_res},
      '{16'h0000, 16'h0000, 16'h8000, 0, zero_res},
      '{16'h8000, 16'h8000, 16'h8000, 0, zero_res},
      '{16'h7fff, 16'h7fff, 16'h7fff, 0, zero_res},
      '{16'h0001, 16'hffff, 16'h0001, 0, zero_res},
      '{16'h0064, 16'h0000, 16'h0000, 0, zero_res},
      '{16'h0000, 16'h0064, 16'h03e8, 0, zero_res}
    };
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults
    foreach (directed[i])
      send_cmd(directed[i].vx, directed[i].vy, directed[i].wz, 1,
               directed[i].typed, directed[i].want);
    wait_idle();

    // zero rotation arm
    set_config(50000, 0, 0, 4864, 9000, 0);
    send_cmd(16'h7fff, 16'h1234, 16'h8000, 1, 1, bad_res);
    send_cmd(16'h0000, 16'h0000, 16'h0000, 1, 1, bad_res);
    wait_idle();
    // zero radius, max gear, zero limit, full reverse mask
    set_config(0, 4095, 4095, 65535, 0, 15);
    send_cmd(16'h0001, 16'h0000, 16'h0000, 1);
    send_cmd(16'h0000, 16'h0000, 16'h0000, 1, 1, zero_res);
    send_cmd(16'h8000, 16'h7fff, 16'h8000, 1);
    wait_idle();
    // zero gear ratio, largest radius and limit
    set_config(262143, 4095, 0, 0, 65535, 5);
    send_cmd(16'h7fff, 16'h8000, 16'h7fff, 1, 1, zero_res);
    send_cmd(16'h8000, 16'h8000, 16'h8000, 1);
    wait_idle();
    set_config(1, 1, 0, 1, 1, 10);
    send_cmd(16'h7fff, 16'h0000, 16'h0000, 1);
    send_cmd(16'h0003, 16'hfffd, 16'h0005, 1);
    wait_idle();

    // random phases, each with its own configuration
    for (int ph = 0; ph < 8; ph++) begin
      set_config($urandom_range(1000, 262143), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(1, 65535),
                 (ph == 1) ? 65535 : $urandom_range(1, 65535), $urandom_range(0, 15));
      if (ph == 2) hold_off = 1'b1;
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        mode = $urandom_range(0, 2);
        send_cmd(rand_vel(mode), rand_vel(mode), rand_vel(mode), (i % 40) >= 15);
      end
      wait_idle();
    end

    $display("sent %0d commands over 13 register settings, checked %0d results",
             n_sent, n_checked);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
